/* src/pbm_pkg.sv */
// shared types, codes and sizes for the polling bus master
`timescale 1ns / 1ps

package pbm_pkg;

   // station table size and poll commands sent to each station
   localparam int STATION_COUNT = 16;
   localparam int STATION_AW    = $clog2(STATION_COUNT);
   localparam int POLL_COMMANDS = 5;

   // configuration reset values
   localparam logic [7:0]  THRESHOLD_RESET = 8'd3;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd200;
   localparam logic [15:0] GAP_RESET       = 16'd50;
   localparam logic [3:0]  ADDR_MIN_RESET  = 4'd1;
   localparam logic [3:0]  ADDR_MAX_RESET  = 4'd15;

   // limits
   localparam logic [7:0] FAIL_MAX  = 8'd255;
   localparam logic [7:0] VALVE_MAX = 8'd8;

   // configuration register indexes
   localparam logic [2:0] CSR_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_TIMEOUT   = 3'd1;
   localparam logic [2:0] CSR_GAP       = 3'd2;
   localparam logic [2:0] CSR_ADDR_MIN  = 3'd3;
   localparam logic [2:0] CSR_ADDR_MAX  = 3'd4;

   // bus command codes issued by the master
   localparam logic [2:0] CMD_START = 3'd5;
   localparam logic [2:0] CMD_STOP  = 3'd6;

   // station link status codes
   localparam logic [1:0] LINK_UNKNOWN = 2'd0;
   localparam logic [1:0] LINK_ONLINE  = 2'd1;
   localparam logic [1:0] LINK_OFFLINE = 2'd2;

   // kinds of input item
   typedef enum logic [2:0] {
      REQ_TICK     = 3'd0,
      REQ_RESPONSE = 3'd1,
      REQ_START    = 3'd2,
      REQ_STOP     = 3'd3,
      REQ_QUERY    = 3'd4
   } pbm_req_kind_type;

   // one result item
   typedef struct packed {
      logic       send_valid;
      logic [3:0] send_addr;
      logic [2:0] send_cmd;
      logic [7:0] send_seq;
      logic       accepted;
      logic       response_matched;
      logic       busy_res;
      logic [1:0] station_online;
      logic [7:0] station_failures;
      logic [7:0] station_error_code;
   } pbm_rsp_type;

endpackage

/* src/pbm_if.sv */
// handshake channel interfaces for requests, results and register writes
`timescale 1ns / 1ps

interface pbm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [7:0]  station_addr;
   logic [7:0]  frame_seq;
   logic [2:0]  frame_cmd;
   logic        is_response;
   logic        is_error;
   logic [7:0]  payload_len;
   logic [7:0]  payload_first;
   logic [7:0]  valve_no;
   logic [31:0] duration_sec;

   modport source (
      output valid, req_type, station_addr, frame_seq, frame_cmd, is_response,
             is_error, payload_len, payload_first, valve_no, duration_sec,
      input  ready
   );
   modport sink (
      input  valid, req_type, station_addr, frame_seq, frame_cmd, is_response,
             is_error, payload_len, payload_first, valve_no, duration_sec,
      output ready
   );
endinterface

interface pbm_rsp_if;
   logic       valid;
   logic       ready;
   logic       send_valid;
   logic [3:0] send_addr;
   logic [2:0] send_cmd;
   logic [7:0] send_seq;
   logic       accepted;
   logic       response_matched;
   logic       busy_res;
   logic [1:0] station_online;
   logic [7:0] station_failures;
   logic [7:0] station_error_code;

   modport source (
      output valid, send_valid, send_addr, send_cmd, send_seq, accepted,
             response_matched, busy_res, station_online, station_failures,
             station_error_code,
      input  ready
   );
   modport sink (
      input  valid, send_valid, send_addr, send_cmd, send_seq, accepted,
             response_matched, busy_res, station_online, station_failures,
             station_error_code,
      output ready
   );
endinterface

interface pbm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  reg_index;
   logic [15:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

/* src/polling_bus_master.sv */
// polling bus master: request scheduling, timeouts and station status table
`timescale 1ns / 1ps

// Takes one item per clock while req_if.ready is high and answers each with
// exactly one result item, registered in the output buffer. All decisions
// for an item (tick timeout and poll send, response match, start/stop checks,
// status query) are made in a single pass through the state registers and
// the 16-entry station table, so the rate is one item per cycle. A two-entry
// output buffer lets req_if.ready stay high while one result waits on a
// stalled rsp_if; ready drops only when both entries are full. Register
// writes on csr_if are always taken and should only be issued while the
// block is idle.
module polling_bus_master
   import pbm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   pbm_req_if.sink   req_if,
   pbm_rsp_if.source rsp_if,
   pbm_csr_if.sink   csr_if
);

   // configuration registers
   logic [7:0]  threshold_ff;
   logic [15:0] timeout_ff;
   logic [15:0] gap_ff;
   logic [3:0]  addr_min_ff;
   logic [3:0]  addr_max_ff;

   // master state
   logic        waiting_ff, waiting_in;
   logic [3:0]  pend_addr_ff, pend_addr_in;
   logic [2:0]  pend_cmd_ff, pend_cmd_in;
   logic [7:0]  pend_seq_ff, pend_seq_in;
   logic [7:0]  seq_ff, seq_in;
   logic [31:0] last_send_ff, last_send_in;
   logic        ever_sent_ff, ever_sent_in;
   logic [31:0] now_ff, now_in;
   logic [3:0]  poll_addr_ff, poll_addr_in;
   logic [2:0]  poll_idx_ff, poll_idx_in;

   // station table
   logic [1:0] link_ff [STATION_COUNT];
   logic [7:0] fail_ff [STATION_COUNT];
   logic [7:0] err_ff  [STATION_COUNT];

   // table write
   logic                  tbl_we;
   logic [STATION_AW-1:0] tbl_idx;
   logic                  link_we, fail_we, err_we;
   logic [1:0]            link_wd;
   logic [7:0]            fail_wd, err_wd;

   // output buffer
   pbm_rsp_type out_ff, out_in, skid_ff, skid_in, rsp_new;
   logic        out_v_ff, out_v_in, skid_v_ff, skid_v_in;

   // datapath helpers
   logic                  push, pop;
   logic                  in_table;
   logic [STATION_AW-1:0] rd_idx;
   logic [1:0]            rd_link;
   logic [7:0]            rd_fail, rd_err;
   logic [31:0]           now_inc, elapsed;
   logic                  timed_out, poll_go;
   logic [7:0]            fail_inc, thr_eff;
   logic                  addr_ok, match;
   logic                  issue_go;
   logic [3:0]            issue_addr;
   logic [2:0]            issue_cmd;
   logic [3:0]            idx_sum;
   logic [4:0]            addr_sum;

   assign push = req_if.valid && req_if.ready;
   assign pop  = out_v_ff && rsp_if.ready;
   assign req_if.ready = !skid_v_ff;
   assign csr_if.ready = 1'b1;

   // table read: pending station on a tick, item address otherwise
   assign in_table = (req_if.station_addr < 8'(STATION_COUNT));
   assign rd_idx   = (req_if.req_type == REQ_TICK) ? pend_addr_ff[STATION_AW-1:0]
                                                   : req_if.station_addr[STATION_AW-1:0];
   assign rd_link  = link_ff[rd_idx];
   assign rd_fail  = fail_ff[rd_idx];
   assign rd_err   = err_ff[rd_idx];

   // millisecond clock and wrapping elapsed time since last send
   assign now_inc   = now_ff + 32'd1;
   assign elapsed   = now_inc - last_send_ff;
   assign timed_out = waiting_ff && (elapsed >= {16'd0, timeout_ff});
   assign poll_go   = (!waiting_ff || timed_out)
                      && (!ever_sent_ff || elapsed >= {16'd0, gap_ff});

   // failure count saturating, threshold zero acts as one
   assign fail_inc = (rd_fail == FAIL_MAX) ? rd_fail : rd_fail + 8'd1;
   assign thr_eff  = (threshold_ff == 8'd0) ? 8'd1 : threshold_ff;

   // request checks
   assign addr_ok = (req_if.station_addr >= {4'd0, addr_min_ff})
                    && (req_if.station_addr <= {4'd0, addr_max_ff});
   assign match   = waiting_ff && (req_if.station_addr == {4'd0, pend_addr_ff})
                    && (req_if.frame_seq == pend_seq_ff)
                    && (req_if.frame_cmd == pend_cmd_ff) && req_if.is_response;

   // poll position advance
   assign idx_sum  = {1'b0, poll_idx_ff} + 4'd1;
   assign addr_sum = {1'b0, poll_addr_ff} + 5'd1;

   // per item decisions
   always_comb begin
      waiting_in   = waiting_ff;
      pend_addr_in = pend_addr_ff;
      pend_cmd_in  = pend_cmd_ff;
      pend_seq_in  = pend_seq_ff;
      seq_in       = seq_ff;
      last_send_in = last_send_ff;
      ever_sent_in = ever_sent_ff;
      now_in       = now_ff;
      poll_addr_in = poll_addr_ff;
      poll_idx_in  = poll_idx_ff;
      tbl_we       = 1'b0;
      tbl_idx      = rd_idx;
      link_we      = 1'b0;
      fail_we      = 1'b0;
      err_we       = 1'b0;
      link_wd      = LINK_ONLINE;
      fail_wd      = 8'd0;
      err_wd       = 8'd0;
      issue_go     = 1'b0;
      issue_addr   = req_if.station_addr[3:0];
      issue_cmd    = CMD_START;
      rsp_new      = '0;

      case (req_if.req_type)
         REQ_TICK: begin
            now_in = now_inc;
            if (timed_out) begin
               waiting_in = 1'b0;
               tbl_we     = 1'b1;
               fail_we    = 1'b1;
               fail_wd    = fail_inc;
               link_we    = (fail_inc >= thr_eff);
               link_wd    = LINK_OFFLINE;
            end
            if (poll_go) begin
               issue_go   = 1'b1;
               issue_addr = poll_addr_ff;
               issue_cmd  = poll_idx_ff;
               if (idx_sum >= 4'(POLL_COMMANDS)) begin
                  poll_idx_in = 3'd0;
                  poll_addr_in = (addr_sum > {1'b0, addr_max_ff}) ? addr_min_ff
                                                                  : addr_sum[3:0];
               end else begin
                  poll_idx_in = idx_sum[2:0];
               end
            end
         end
         REQ_RESPONSE: begin
            if (match) begin
               waiting_in = 1'b0;
               tbl_we     = 1'b1;
               link_we    = 1'b1;
               link_wd    = LINK_ONLINE;
               fail_we    = 1'b1;
               fail_wd    = 8'd0;
               if (req_if.is_error) begin
                  err_we = (req_if.payload_len != 8'd0);
                  err_wd = req_if.payload_first;
               end else begin
                  err_we = ((req_if.frame_cmd == CMD_START) && (req_if.payload_len >= 8'd2))
                           || ((req_if.frame_cmd == CMD_STOP) && (req_if.payload_len >= 8'd3));
                  err_wd = 8'd0;
               end
               rsp_new.response_matched = 1'b1;
            end
         end
         REQ_START: begin
            if (!waiting_ff && addr_ok && (req_if.valve_no >= 8'd1)
                && (req_if.valve_no <= VALVE_MAX) && (req_if.duration_sec != 32'd0)) begin
               issue_go          = 1'b1;
               issue_cmd         = CMD_START;
               rsp_new.accepted  = 1'b1;
            end
         end
         REQ_STOP: begin
            if (!waiting_ff && addr_ok) begin
               issue_go          = 1'b1;
               issue_cmd         = CMD_STOP;
               rsp_new.accepted  = 1'b1;
            end
         end
         REQ_QUERY: begin
            if (in_table) begin
               rsp_new.station_online     = rd_link;
               rsp_new.station_failures   = rd_fail;
               rsp_new.station_error_code = rd_err;
            end
         end
         default: begin
         end
      endcase

      // issue a request frame
      if (issue_go) begin
         seq_in       = seq_ff + 8'd1;
         pend_addr_in = issue_addr;
         pend_cmd_in  = issue_cmd;
         pend_seq_in  = seq_ff + 8'd1;
         last_send_in = now_in;
         ever_sent_in = 1'b1;
         waiting_in   = 1'b1;
         rsp_new.send_valid = 1'b1;
         rsp_new.send_addr  = issue_addr;
         rsp_new.send_cmd   = issue_cmd;
         rsp_new.send_seq   = seq_ff + 8'd1;
      end
      rsp_new.busy_res = waiting_in;
   end

   // output buffer: main register plus skid entry
   always_comb begin
      out_in    = out_ff;
      out_v_in  = out_v_ff;
      skid_in   = skid_ff;
      skid_v_in = skid_v_ff;
      if (skid_v_ff) begin
         if (pop) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff || pop) begin
            out_in   = rsp_new;
            out_v_in = 1'b1;
         end else begin
            skid_in   = rsp_new;
            skid_v_in = 1'b1;
         end
      end else if (pop) begin
         out_v_in = 1'b0;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         gap_ff       <= GAP_RESET;
         addr_min_ff  <= ADDR_MIN_RESET;
         addr_max_ff  <= ADDR_MAX_RESET;
      end else if (csr_if.valid) begin
         case (csr_if.reg_index)
            CSR_THRESHOLD: threshold_ff <= csr_if.wdata[7:0];
            CSR_TIMEOUT:   timeout_ff   <= csr_if.wdata;
            CSR_GAP:       gap_ff       <= csr_if.wdata;
            CSR_ADDR_MIN:  addr_min_ff  <= csr_if.wdata[3:0];
            CSR_ADDR_MAX:  addr_max_ff  <= csr_if.wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // master state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff   <= 1'b0;
         pend_addr_ff <= 4'd0;
         pend_cmd_ff  <= 3'd0;
         pend_seq_ff  <= 8'd0;
         seq_ff       <= 8'd0;
         last_send_ff <= 32'd0;
         ever_sent_ff <= 1'b0;
         now_ff       <= 32'd0;
         poll_addr_ff <= ADDR_MIN_RESET;
         poll_idx_ff  <= 3'd0;
      end else if (push) begin
         waiting_ff   <= waiting_in;
         pend_addr_ff <= pend_addr_in;
         pend_cmd_ff  <= pend_cmd_in;
         pend_seq_ff  <= pend_seq_in;
         seq_ff       <= seq_in;
         last_send_ff <= last_send_in;
         ever_sent_ff <= ever_sent_in;
         now_ff       <= now_in;
         poll_addr_ff <= poll_addr_in;
         poll_idx_ff  <= poll_idx_in;
      end
   end

   // station table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STATION_COUNT; i++) begin
            link_ff[i] <= LINK_UNKNOWN;
            fail_ff[i] <= 8'd0;
            err_ff[i]  <= 8'd0;
         end
      end else if (push && tbl_we) begin
         if (link_we) link_ff[tbl_idx] <= link_wd;
         if (fail_we) fail_ff[tbl_idx] <= fail_wd;
         if (err_we)  err_ff[tbl_idx]  <= err_wd;
      end
   end

   // output buffer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // result channel
   assign rsp_if.valid              = out_v_ff;
   assign rsp_if.send_valid         = out_ff.send_valid;
   assign rsp_if.send_addr          = out_ff.send_addr;
   assign rsp_if.send_cmd           = out_ff.send_cmd;
   assign rsp_if.send_seq           = out_ff.send_seq;
   assign rsp_if.accepted           = out_ff.accepted;
   assign rsp_if.response_matched   = out_ff.response_matched;
   assign rsp_if.busy_res           = out_ff.busy_res;
   assign rsp_if.station_online     = out_ff.station_online;
   assign rsp_if.station_failures   = out_ff.station_failures;
   assign rsp_if.station_error_code = out_ff.station_error_code;

endmodule

/* src/pbm_checker.sv */
// port level checks for the polling bus master and their bind
`timescale 1ns / 1ps

module pbm_port_checks
   import pbm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       send_valid,
   input logic [2:0] send_cmd,
   input logic       accepted,
   input logic       response_matched,
   input logic       busy_res,
   input logic [1:0] station_online
);

   // a stalled result item stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // an issued request leaves the master busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && send_valid |-> busy_res)
      else $error("request issued but master not busy");

   // start or stop acceptance always issues its command
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && accepted |-> send_valid && (send_cmd == CMD_START || send_cmd == CMD_STOP))
      else $error("accepted item without start or stop frame");

   // a matched response frees the master and sends nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && response_matched |-> !busy_res && !send_valid && !accepted)
      else $error("matched response left master busy");

   // status code is never the unused value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> station_online != 2'd3)
      else $error("invalid station status code");

endmodule

bind polling_bus_master pbm_port_checks u_port_checks (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .send_valid       (rsp_if.send_valid),
   .send_cmd         (rsp_if.send_cmd),
   .accepted         (rsp_if.accepted),
   .response_matched (rsp_if.response_matched),
   .busy_res         (rsp_if.busy_res),
   .station_online   (rsp_if.station_online)
);
